FILE: sv/ftb_pkg.sv
// ----------------------------------------------------------------------------
// ftb_pkg: shared types and constants of the flow tuple blocklist
// Request and tuple layouts, operation and verdict codes, default depth.
// ----------------------------------------------------------------------------
package ftb_pkg;

  // default number of rule entries
  localparam int RULE_ENTRIES_DEF = 128;

  // operation codes
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_PASS       = 2'd0;
  localparam logic [1:0] VERDICT_DROP       = 2'd1;
  localparam logic [1:0] VERDICT_DROP_RESET = 2'd2;

  // protocol number of TCP
  localparam logic [7:0] PROTO_TCP = 8'd6;

  // one five-tuple, as stored in a rule entry
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dst_port;
    logic [7:0]  proto;
  } tuple_t;

  // one request as it travels from the front to the back
  typedef struct packed {
    logic   op;
    tuple_t tuple;
  } req_t;

endpackage

FILE: sv/ftb_ram.sv
// ----------------------------------------------------------------------------
// ftb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ftb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/ftb_queue.sv
// ----------------------------------------------------------------------------
// ftb_queue: two-entry request queue between front and back
// Lets the front keep accepting while the back is busy with a scan.
// ----------------------------------------------------------------------------
module ftb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ftb_pkg::req_t push_req,
  output logic          full,
  output logic          q_valid,
  output ftb_pkg::req_t q_req,
  input  logic          pop
);
  import ftb_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic do_push;
  logic do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  // fill count never exceeds two
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");

  // pointers differ exactly when one entry is held
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r != rd_ptr_r) == (cnt_r == 2'd1)) else $error("queue pointers disagree");

  // push offered while full is held off
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !do_pop) |=> full) else $error("queue lost an entry");

endmodule

FILE: sv/ftb_engine.sv
// ----------------------------------------------------------------------------
// ftb_engine: back part of the flow tuple blocklist
// Appends rules to the rule RAM and scans it one entry a cycle on classify.
// ----------------------------------------------------------------------------
module ftb_engine #(
  parameter int RULE_ENTRIES = ftb_pkg::RULE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ftb_pkg::req_t q_req,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_verdict,
  output logic          out_table_full,
  output logic [7:0]    out_rules_used
);
  import ftb_pkg::*;

  localparam int AW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int CW = $clog2(RULE_ENTRIES + 1);
  localparam int TW = $bits(tuple_t);
  localparam logic [CW-1:0] FULL_CNT = CW'(RULE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  req_t          cur_r, cur_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic          hit_r, hit_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_verdict_r, out_verdict_nxt;
  logic          out_full_r, out_full_nxt;
  logic [7:0]    out_used_r, out_used_nxt;

  logic          out_free;
  logic          wr_en;
  logic          rd_en;
  logic [TW-1:0] rd_data;
  logic          rd_match;

  assign out_free = !out_valid_r || out_ready;
  assign rd_match = (tuple_t'(rd_data) == cur_r.tuple);

  ftb_ram #(
    .WIDTH (TW),
    .DEPTH (RULE_ENTRIES),
    .AW    (AW)
  ) u_rule_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (cur_r.tuple),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // sequence one request: take it, append or scan, then post the result
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    hit_nxt         = hit_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_verdict_nxt = out_verdict_r;
    out_full_nxt    = out_full_r;
    out_used_nxt    = out_used_r;
    q_pop           = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_nxt  = q_req;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          hit_nxt  = 1'b0;
          state_nxt = (q_req.op == OP_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = VERDICT_PASS;
          if (count_r == FULL_CNT) begin
            out_full_nxt = 1'b1;
            out_used_nxt = 8'(count_r);
          end else begin
            wr_en        = 1'b1;
            count_nxt    = count_r + 1'b1;
            out_full_nxt = 1'b0;
            out_used_nxt = 8'(count_nxt);
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle, issue the next read
        if (pend_r && rd_match) begin
          hit_nxt = 1'b1;
        end
        if (idx_r < count_r) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = 1'b0;
          out_used_nxt  = 8'(count_r);
          if (!hit_r) begin
            out_verdict_nxt = VERDICT_PASS;
          end else if (cur_r.tuple.proto == PROTO_TCP) begin
            out_verdict_nxt = VERDICT_DROP_RESET;
          end else begin
            out_verdict_nxt = VERDICT_DROP;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    idx_r         <= idx_nxt;
    pend_r        <= pend_nxt;
    hit_r         <= hit_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_full_r    <= out_full_nxt;
    out_used_r    <= out_used_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_table_full = out_full_r;
  assign out_rules_used = out_used_r;

  // rule count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("rule count above table depth");

  // a rule is written only into a free entry
  a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r < FULL_CNT)) else $error("rule write into full table");

  // count moves only on a write
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(count_r)) else $error("rule count changed without a write");

  // scan reads only stored entries
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (idx_r < count_r)) else $error("scan read beyond stored rules");

endmodule

FILE: sv/flow_tuple_blocklist.sv
// ----------------------------------------------------------------------------
// flow_tuple_blocklist: exact-match blocklist of IPv4 five-tuple flows
// Add requests append rules; classify requests return pass, drop or
// drop-with-reset after a scan of the stored rules.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    op, addresses, ports, proto
//   out_     output     out_valid / out_ready  verdict, table_full, rules_used
//
// A request is popped from the queue, then an add writes the result register;
// a classify scans first: the rule RAM read port visits one entry a cycle,
// followed by the last compare, the end of the scan and the result register.
// Reset clears the rule count, queue and output register; no clearing pass.
// A two-entry queue keeps in_ready high while a scan runs until two requests
// wait; a stalled result holds the back part, and the queue then fills and drops in_ready.
// ----------------------------------------------------------------------------
module flow_tuple_blocklist #(
  parameter int RULE_ENTRIES = ftb_pkg::RULE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_sport,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_proto,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_verdict,
  output logic        out_table_full,
  output logic [7:0]  out_rules_used
);
  import ftb_pkg::*;

  req_t in_req;
  logic q_full;
  logic q_valid;
  req_t q_req;
  logic q_pop;

  // pack the incoming request
  always_comb begin
    in_req.op             = in_op;
    in_req.tuple.src_addr = in_src_addr;
    in_req.tuple.dst_addr = in_dst_addr;
    in_req.tuple.sport    = in_sport;
    in_req.tuple.dst_port = in_dst_port;
    in_req.tuple.proto    = in_proto;
  end

  assign in_ready = !q_full;

  ftb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_req (in_req),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .pop      (q_pop)
  );

  ftb_engine #(
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_req          (q_req),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_verdict    (out_verdict),
    .out_table_full (out_table_full),
    .out_rules_used (out_rules_used)
  );

endmodule

FILE: tb/flow_tuple_blocklist_tb.sv
// ----------------------------------------------------------------------------
// flow_tuple_blocklist_tb: self-checking bench of the five-tuple blocklist
// Adds rules and classifies packet tuples through the valid/ready channels,
// predicts every result from a local copy of the rule table and compares
// each result field by field, in order, under random idling and stalls.
// ----------------------------------------------------------------------------
module flow_tuple_blocklist_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftb_pkg::*;

  localparam int ENTRIES = RULE_ENTRIES_DEF;

  // protocol number of UDP
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // one expected result
  typedef struct packed {
    logic [1:0] verdict;
    logic       table_full;
    logic [7:0] rules_used;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [31:0] in_src_addr;
  logic [31:0] in_dst_addr;
  logic [15:0] in_sport;
  logic [15:0] in_dst_port;
  logic [7:0]  in_proto;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_verdict;
  logic        out_table_full;
  logic [7:0]  out_rules_used;

  // local copy of the blocklist
  tuple_t   rule_tab [ENTRIES];
  int       rules_stored = 0;
  outcome_t outcome_q [$];

  int mismatches      = 0;
  bit idle_en         = 1'b1;
  int hold_cycles_req = 0;

  flow_tuple_blocklist DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_src_addr    (in_src_addr),
    .in_dst_addr    (in_dst_addr),
    .in_sport       (in_sport),
    .in_dst_port    (in_dst_port),
    .in_proto       (in_proto),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_verdict    (out_verdict),
    .out_table_full (out_table_full),
    .out_rules_used (out_rules_used)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // end the run if it hangs
  initial begin
    #20_000_000;
    $display("flow_tuple_blocklist: mismatch");
    $finish;
  end

  // Apply one request to the local table and return the verdict it earns
  function automatic outcome_t blocklist_outcome(input logic op, input tuple_t t);
    outcome_t o;
    bit       hit;
    hit          = 1'b0;
    o.verdict    = VERDICT_PASS;
    o.table_full = 1'b0;
    if (op == OP_ADD) begin
      if (rules_stored >= ENTRIES) begin
        o.table_full = 1'b1;
      end else begin
        rule_tab[rules_stored] = t;
        rules_stored++;
      end
    end else begin
      for (int i = 0; i < rules_stored; i++) begin
        if (rule_tab[i] == t) hit = 1'b1;
      end
      if (hit) o.verdict = (t.proto == PROTO_TCP) ? VERDICT_DROP_RESET : VERDICT_DROP;
    end
    o.rules_used = rules_stored[7:0];
    return o;
  endfunction

  function automatic tuple_t make_tuple(input logic [31:0] sa, input logic [31:0] da,
                                        input logic [15:0] sp, input logic [15:0] dp,
                                        input logic [7:0] pr);
    tuple_t t;
    t.src_addr = sa;
    t.dst_addr = da;
    t.sport    = sp;
    t.dst_port = dp;
    t.proto    = pr;
    return t;
  endfunction

  // Random tuple, biased toward field extremes and common protocols
  function automatic tuple_t random_tuple();
    tuple_t t;
    int     sel;
    t.src_addr = $urandom();
    t.dst_addr = $urandom();
    t.sport    = 16'($urandom());
    t.dst_port = 16'($urandom());
    t.proto    = 8'($urandom());
    sel = $urandom_range(0, 9);
    if (sel == 0) t.src_addr = '0;
    if (sel == 1) t.dst_addr = '1;
    if (sel == 2) t.sport = '1;
    if (sel == 3) t.dst_port = '0;
    sel = $urandom_range(0, 9);
    if (sel < 4) t.proto = PROTO_TCP;
    else if (sel < 7) t.proto = PROTO_UDP;
    return t;
  endfunction

  // Flip one bit somewhere in a tuple
  function automatic tuple_t near_miss(input tuple_t t);
    logic [$bits(tuple_t)-1:0] v;
    int                        pos;
    v      = t;
    pos    = $urandom_range(0, $bits(tuple_t) - 1);
    v[pos] = ~v[pos];
    return tuple_t'(v);
  endfunction

  // Offer one request, hold it until accepted, then record its expected result
  task automatic send_request(input logic op, input tuple_t t);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_src_addr <= t.src_addr;
    in_dst_addr <= t.dst_addr;
    in_sport    <= t.sport;
    in_dst_port <= t.dst_port;
    in_proto    <= t.proto;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    outcome_q.push_back(blocklist_outcome(op, t));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (outcome_q.size() != 0 && waited < 20000);
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        note_mismatch("unexpected result, rules_used", -1, out_rules_used);
      end else begin
        want = outcome_q.pop_front();
        if (out_verdict !== want.verdict)
          note_mismatch("verdict", want.verdict, out_verdict);
        if (out_table_full !== want.table_full)
          note_mismatch("table_full", want.table_full, out_table_full);
        if (out_rules_used !== want.rules_used)
          note_mismatch("rules_used", want.rules_used, out_rules_used);
      end
    end
  end

  // Result side: random stall bursts, or one long hold-off on request
  initial begin
    int held;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles_req > 0) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < hold_cycles_req) begin
          @(posedge clk);
          held++;
        end
        hold_cycles_req = 0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Classify with nothing stored: everything passes
  task automatic test_empty_table();
    send_request(OP_CLASSIFY, make_tuple('0, '0, '0, '0, '0));
    send_request(OP_CLASSIFY, make_tuple('1, '1, '1, '1, '1));
    send_request(OP_CLASSIFY, random_tuple());
  endtask

  // Field extremes, TCP and non-TCP hits, duplicates and single-field misses
  task automatic test_directed_rules();
    tuple_t r_zero, r_ones, r_tcp, r_udp, t;
    r_zero = make_tuple('0, '0, '0, '0, '0);
    r_ones = make_tuple('1, '1, '1, '1, '1);
    r_tcp  = make_tuple(32'hC0A8_0001, 32'h0A00_0002, 16'd40000, 16'd443, PROTO_TCP);
    r_udp  = make_tuple(32'h0A01_0203, 32'h0808_0808, 16'd5353, 16'd53, PROTO_UDP);
    send_request(OP_ADD, r_zero);
    send_request(OP_ADD, r_ones);
    send_request(OP_ADD, r_tcp);
    send_request(OP_ADD, r_udp);
    send_request(OP_ADD, r_tcp);
    send_request(OP_CLASSIFY, r_zero);
    send_request(OP_CLASSIFY, r_ones);
    send_request(OP_CLASSIFY, r_tcp);
    send_request(OP_CLASSIFY, r_udp);
    // same flow on another protocol
    t = r_tcp;
    t.proto = PROTO_UDP;
    send_request(OP_CLASSIFY, t);
    // reverse direction of the ports
    t = r_tcp;
    t.sport    = r_tcp.dst_port;
    t.dst_port = r_tcp.sport;
    send_request(OP_CLASSIFY, t);
    // one bit off in each field
    t = r_udp;
    t.src_addr[0] = ~t.src_addr[0];
    send_request(OP_CLASSIFY, t);
    t = r_udp;
    t.dst_addr[31] = ~t.dst_addr[31];
    send_request(OP_CLASSIFY, t);
    t = r_udp;
    t.sport[15] = ~t.sport[15];
    send_request(OP_CLASSIFY, t);
    t = r_udp;
    t.dst_port[0] = ~t.dst_port[0];
    send_request(OP_CLASSIFY, t);
    t = r_udp;
    t.proto[7] = ~t.proto[7];
    send_request(OP_CLASSIFY, t);
  endtask

  // Mostly lookups of stored flows, some near misses, noise and new rules
  task automatic run_mixed_traffic(input int count);
    tuple_t t;
    int     pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_request(OP_ADD, random_tuple());
      end else begin
        if (pick < 65 && rules_stored > 0)
          t = rule_tab[$urandom_range(0, rules_stored - 1)];
        else if (pick < 80 && rules_stored > 0)
          t = near_miss(rule_tab[$urandom_range(0, rules_stored - 1)]);
        else
          t = random_tuple();
        send_request(OP_CLASSIFY, t);
      end
    end
  endtask

  // Hold the result side off long enough for the input to stall
  task automatic test_backpressure();
    hold_cycles_req = 400;
    for (int k = 0; k < 12; k++) begin
      if (rules_stored > 0 && k[0])
        send_request(OP_CLASSIFY, rule_tab[$urandom_range(0, rules_stored - 1)]);
      else
        send_request(OP_CLASSIFY, random_tuple());
    end
    drain_results();
  endtask

  // Fill every entry, then try more adds and look up the first and last rules
  task automatic test_table_full();
    while (rules_stored < ENTRIES) send_request(OP_ADD, random_tuple());
    repeat (5) send_request(OP_ADD, random_tuple());
    send_request(OP_CLASSIFY, rule_tab[0]);
    send_request(OP_CLASSIFY, rule_tab[ENTRIES - 1]);
    send_request(OP_CLASSIFY, near_miss(rule_tab[ENTRIES - 1]));
  endtask

  // Back-to-back traffic on a full table, no idling on either side
  task automatic test_full_rate();
    idle_en = 1'b0;
    run_mixed_traffic(950);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_op       <= OP_ADD;
    in_src_addr <= '0;
    in_dst_addr <= '0;
    in_sport    <= '0;
    in_dst_port <= '0;
    in_proto    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed_rules();
    run_mixed_traffic(960);
    test_backpressure();
    test_table_full();
    test_full_rate();

    // let the last scan finish before judging
    drain_results();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("flow_tuple_blocklist: match");
    end else begin
      $display("flow_tuple_blocklist: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ftb_pkg.sv
sv/ftb_ram.sv
sv/ftb_queue.sv
sv/ftb_engine.sv
sv/flow_tuple_blocklist.sv
tb/flow_tuple_blocklist_tb.sv
